>>> rtl/core/hmm_pkg.sv
// Shared types, constants and the bus address decoder for the handheld memory map.
// Used by the front end, back end and top level of the memory map core; depends on nothing.
package hmm_pkg;

   localparam int ROM_BYTES        = 32768;
   localparam int DMA_TOTAL_CYCLES = 640;
   localparam int CYCLES_PER_BYTE  = 4;

   localparam int LEFT_W    = 10;
   localparam int PEND_W    = 17;
   localparam int ADDR_W    = 16;
   localparam int RAM_DEPTH = 49664;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   localparam logic [RAM_AW-1:0] CLEAR_FIRST = RAM_AW'(32768);
   localparam logic [RAM_AW-1:0] CLEAR_LAST  = RAM_AW'(RAM_DEPTH - 1);
   localparam logic [7:0]        UNMAPPED_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      ACT_READ      = 2'd0,
      ACT_WRITE     = 2'd1,
      ACT_DMA_START = 2'd2,
      ACT_TICK      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_DMA_CHK,
      ST_DMA_WR
   } back_state_type;

   typedef struct packed {
      logic              mapped;
      logic [RAM_AW-1:0] phys;
   } decode_type;

   typedef struct packed {
      action_type        action;
      logic              mapped;
      logic [RAM_AW-1:0] phys;
      logic [7:0]        wdata;
      logic [15:0]       dest;
      logic [15:0]       src;
      logic [15:0]       cycles;
   } entry_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   // Maps a bus address onto one physical RAM: ROM, then video RAM, then work RAM,
   // then the top page holding OAM, IO, high RAM and the interrupt-enable byte.
   function automatic decode_type bus_decode(input logic [15:0] a, input logic cart);
      decode_type d;
      d.mapped = 1'b1;
      d.phys   = RAM_AW'(a);
      priority if (a[15] == 1'b0) begin
         d.mapped = cart && ({1'b0, a} < 17'(ROM_BYTES));
         d.phys   = RAM_AW'(a);
      end else if (a[15:13] == 3'b100) begin
         d.phys = RAM_AW'({3'b100, a[12:0]});
      end else if (a[15:13] == 3'b101) begin
         d.mapped = 1'b0;
      end else if (a < 16'hFE00) begin
         d.phys = RAM_AW'({3'b101, a[12:0]});
      end else if (a >= 16'hFEA0 && a <= 16'hFEFF) begin
         d.mapped = 1'b0;
      end else begin
         d.phys = RAM_AW'({7'b1100000, a[8:0]});
      end
      return d;
   endfunction

endpackage

>>> rtl/core/hmm_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module hmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

>>> rtl/core/hmm_front.sv
// Front end: accepts commands, decodes the bus address and queues them for the back end.
// Depends on hmm_pkg.
module hmm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic [15:0]              req_address,
   input  logic [7:0]               req_write_data,
   input  logic [15:0]              req_dma_dest,
   input  logic [15:0]              req_dma_source,
   input  logic [15:0]              req_tick_cycles,
   input  logic                     cartridge_present,
   input  hmm_pkg::back_status_type back_status,
   input  logic                     pop,
   output logic                     q_valid,
   output hmm_pkg::entry_type       q_entry
);
   import hmm_pkg::*;

   entry_type  q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   entry_type  new_entry;
   decode_type dec;

   assign busy    = back_status.busy || (count_ff != 2'd0);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = q_ff[rd_ptr_ff];

   always_comb begin
      dec              = bus_decode(req_address, cartridge_present);
      new_entry.action = action_type'(req_action);
      new_entry.mapped = dec.mapped;
      new_entry.phys   = dec.phys;
      new_entry.wdata  = req_write_data;
      new_entry.dest   = req_dma_dest;
      new_entry.src    = req_dma_source;
      new_entry.cycles = req_tick_cycles;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (pop && q_valid);
      count_in  = count_ff + 2'(push) - 2'(pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

>>> rtl/core/hmm_back.sv
// Back end: clears the internal RAMs after reset, then carries out reads, writes and
// the OAM DMA byte copies on the shared RAM port. Depends on hmm_pkg.
module hmm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cartridge_present,
   input  logic                       q_valid,
   input  hmm_pkg::entry_type         q_entry,
   output logic                       pop,
   output hmm_pkg::back_status_type   back_status,
   output logic                       ram_we,
   output logic [hmm_pkg::RAM_AW-1:0] ram_addr,
   output logic [7:0]                 ram_wdata,
   input  logic [7:0]                 ram_rdata,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_read_data,
   output logic                       rsp_write_ok,
   output logic                       rsp_dma_busy
);
   import hmm_pkg::*;

   back_state_type    state_ff, state_in;
   logic [RAM_AW-1:0] clr_ff, clr_in;
   logic [15:0]       dest_ff, dest_in;
   logic [15:0]       src_ff, src_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              src_map_ff, src_map_in;
   logic              valid_ff, valid_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic              wok_ff, wok_in;
   logic              dbusy_ff, dbusy_in;
   decode_type        src_dec, dest_dec;

   assign back_status.busy = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_write_ok  = wok_ff;
   assign rsp_dma_busy  = dbusy_ff;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      left_in    = left_ff;
      pend_in    = pend_ff;
      src_map_in = src_map_ff;
      valid_in   = 1'b0;
      rdata_in   = 8'd0;
      wok_in     = 1'b0;
      dbusy_in   = (left_ff != '0);
      pop        = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = q_entry.phys;
      ram_wdata  = q_entry.wdata;
      src_dec    = bus_decode(src_ff, cartridge_present);
      dest_dec   = bus_decode(dest_ff, cartridge_present);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = 8'd0;
            clr_in    = clr_ff + RAM_AW'(1);
            if (clr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               unique case (q_entry.action)
                  ACT_READ: begin
                     if (q_entry.mapped) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        valid_in = 1'b1;
                        rdata_in = UNMAPPED_BYTE;
                     end
                  end
                  ACT_WRITE: begin
                     ram_we   = q_entry.mapped;
                     valid_in = 1'b1;
                     wok_in   = q_entry.mapped;
                  end
                  ACT_DMA_START: begin
                     pend_in  = '0;
                     left_in  = LEFT_W'(DMA_TOTAL_CYCLES);
                     dest_in  = q_entry.dest;
                     src_in   = q_entry.src;
                     valid_in = 1'b1;
                     dbusy_in = 1'b1;
                  end
                  ACT_TICK: begin
                     pend_in  = pend_ff + PEND_W'(q_entry.cycles);
                     state_in = ST_DMA_CHK;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            valid_in = 1'b1;
            rdata_in = ram_rdata;
            state_in = ST_IDLE;
         end
         ST_DMA_CHK: begin
            if (pend_ff >= PEND_W'(CYCLES_PER_BYTE) && left_ff >= LEFT_W'(CYCLES_PER_BYTE)) begin
               ram_addr   = src_dec.phys;
               src_map_in = src_dec.mapped;
               state_in   = ST_DMA_WR;
            end else begin
               if (left_ff < LEFT_W'(CYCLES_PER_BYTE)) begin
                  dest_in = '0;
                  src_in  = '0;
                  left_in = '0;
                  pend_in = '0;
               end
               valid_in = 1'b1;
               dbusy_in = (left_ff >= LEFT_W'(CYCLES_PER_BYTE));
               state_in = ST_IDLE;
            end
         end
         ST_DMA_WR: begin
            ram_we    = dest_dec.mapped;
            ram_addr  = dest_dec.phys;
            ram_wdata = src_map_ff ? ram_rdata : UNMAPPED_BYTE;
            dest_in   = dest_ff + 16'd1;
            src_in    = src_ff + 16'd1;
            pend_in   = pend_ff - PEND_W'(CYCLES_PER_BYTE);
            left_in   = left_ff - LEFT_W'(CYCLES_PER_BYTE);
            state_in  = ST_DMA_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= CLEAR_FIRST;
         dest_ff  <= '0;
         src_ff   <= '0;
         left_ff  <= '0;
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         dest_ff  <= dest_in;
         src_ff   <= src_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      src_map_ff <= src_map_in;
      rdata_ff   <= rdata_in;
      wok_ff     <= wok_in;
      dbusy_ff   <= dbusy_in;
   end

endmodule

>>> rtl/core/handheld_memory_map_with_oam_dma_core.sv
// Top level of the handheld memory map with OAM DMA: configuration port, front end,
// back end and the shared RAM. Depends on hmm_pkg, hmm_front, hmm_back and hmm_ram.
//
// After reset the block holds busy high while it zeroes video RAM, work RAM, OAM, IO
// and high RAM through the single RAM port. A command is taken when start is high and
// busy is low; its result appears for one cycle on the rsp_ ports with rsp_valid
// high and cannot be held off. A tick copies the bytes that a running DMA has earned,
// each byte a read and a write of the one RAM port.
module handheld_memory_map_with_oam_dma_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_dma_dest,
   input  logic [15:0] req_dma_source,
   input  logic [15:0] req_tick_cycles,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_write_ok,
   output logic        rsp_dma_busy,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import hmm_pkg::*;

   logic              cart_ff, cart_in;
   logic              q_valid;
   entry_type         q_entry;
   logic              pop;
   back_status_type   back_status;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'd0, cart_ff} : 32'd0;

   always_comb begin
      cart_in = cart_ff;
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
         cart_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_ff <= 1'b0;
      end else begin
         cart_ff <= cart_in;
      end
   end

   hmm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .req_dma_dest      (req_dma_dest),
      .req_dma_source    (req_dma_source),
      .req_tick_cycles   (req_tick_cycles),
      .cartridge_present (cart_ff),
      .back_status       (back_status),
      .pop               (pop),
      .q_valid           (q_valid),
      .q_entry           (q_entry)
   );

   hmm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cartridge_present (cart_ff),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .pop               (pop),
      .back_status       (back_status),
      .ram_we            (ram_we),
      .ram_addr          (ram_addr),
      .ram_wdata         (ram_wdata),
      .ram_rdata         (ram_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_write_ok      (rsp_write_ok),
      .rsp_dma_busy      (rsp_dma_busy)
   );

   hmm_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

>>> rtl/core/hmm_checker.sv
// Port-level checker for the memory map core, attached to the top level by bind.
// Depends only on the top level's ports.
module hmm_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_data,
   input logic       rsp_write_ok
);

   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("Busy is low right after reset.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Busy is low right after a command was taken.");

   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two results in consecutive cycles.");

   a_write_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_ok) |-> (rsp_read_data == 8'd0))
      else $error("A write result carries read data.");

endmodule

bind handheld_memory_map_with_oam_dma_core hmm_checker u_hmm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_read_data (rsp_read_data),
   .rsp_write_ok  (rsp_write_ok)
);

>>> test/tb_handheld_memory_map_with_oam_dma_core.sv
// Testbench for the handheld memory map core with OAM DMA: directed and random
// commands, each result checked against a behavioral model of the memory map.
// Depends on hmm_pkg and handheld_memory_map_with_oam_dma_core.
module tb_handheld_memory_map_with_oam_dma_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hmm_pkg::*;

   typedef struct {
      logic [7:0] read_data;
      logic       write_ok;
      logic       dma_busy;
   } bus_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic [15:0] req_dma_dest = '0;
   logic [15:0] req_dma_source = '0;
   logic [15:0] req_tick_cycles = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_write_ok;
   logic        rsp_dma_busy;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bus_result_type expected_words[$];
   int             error_count = 0;

   logic [7:0]  map_bytes [0:65535];
   bit          rom_written [0:ROM_BYTES-1];
   logic [15:0] rom_addresses[$];
   logic        cart_present;
   logic [15:0] dma_dest_ptr;
   logic [15:0] dma_src_ptr;
   logic [9:0]  dma_left;
   logic [16:0] dma_pending;

   handheld_memory_map_with_oam_dma_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_address(req_address),
      .req_write_data(req_write_data), .req_dma_dest(req_dma_dest),
      .req_dma_source(req_dma_source), .req_tick_cycles(req_tick_cycles),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_write_ok(rsp_write_ok), .rsp_dma_busy(rsp_dma_busy),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   function automatic bit map_key(input logic [15:0] a, output int key);
      key = int'(a);
      if (a < 16'h8000) return cart_present && (a < 16'(ROM_BYTES));
      if (a < 16'hA000) return 1'b1;
      if (a < 16'hC000) return 1'b0;
      if (a < 16'hE000) return 1'b1;
      if (a < 16'hFE00) begin
         key = int'(a - 16'h2000);
         return 1'b1;
      end
      if (a >= 16'hFEA0 && a <= 16'hFEFF) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] model_read(input logic [15:0] a);
      int key;
      if (!map_key(a, key)) return UNMAPPED_BYTE;
      return map_bytes[key];
   endfunction

   function automatic bit model_write(input logic [15:0] a, input logic [7:0] v);
      int key;
      if (!map_key(a, key)) return 1'b0;
      map_bytes[key] = v;
      if (a < 16'h8000 && !rom_written[a]) begin
         rom_written[a] = 1'b1;
         rom_addresses.push_back(a);
      end
      return 1'b1;
   endfunction

   task automatic predict_command(input action_type act, input logic [15:0] addr,
                                  input logic [7:0] wdata, input logic [15:0] dest,
                                  input logic [15:0] src, input logic [15:0] cycles);
      bus_result_type r;
      r.read_data = 8'h00;
      r.write_ok = 1'b0;
      case (act)
         ACT_READ: r.read_data = model_read(addr);
         ACT_WRITE: r.write_ok = model_write(addr, wdata);
         ACT_DMA_START: begin
            dma_pending = '0;
            dma_left = 10'(DMA_TOTAL_CYCLES);
            dma_dest_ptr = dest;
            dma_src_ptr = src;
         end
         default: begin
            dma_pending = dma_pending + 17'(cycles);
            while (dma_pending >= 17'(CYCLES_PER_BYTE) &&
                   dma_left >= 10'(CYCLES_PER_BYTE)) begin
               void'(model_write(dma_dest_ptr, model_read(dma_src_ptr)));
               dma_dest_ptr = dma_dest_ptr + 16'd1;
               dma_src_ptr = dma_src_ptr + 16'd1;
               dma_pending = dma_pending - 17'(CYCLES_PER_BYTE);
               dma_left = dma_left - 10'(CYCLES_PER_BYTE);
            end
            if (dma_left < 10'(CYCLES_PER_BYTE)) begin
               dma_dest_ptr = '0;
               dma_src_ptr = '0;
               dma_left = '0;
               dma_pending = '0;
            end
         end
      endcase
      r.dma_busy = (dma_left != '0);
      expected_words.push_back(r);
   endtask

   always @(posedge clock) begin
      bus_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: read_data %0h", rsp_read_data);
            error_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_read_data !== e.read_data) begin
               $error("read_data expected %0h actual %0h", e.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_write_ok !== e.write_ok) begin
               $error("write_ok expected %0b actual %0b", e.write_ok, rsp_write_ok);
               error_count++;
            end
            if (rsp_dma_busy !== e.dma_busy) begin
               $error("dma_busy expected %0b actual %0b", e.dma_busy, rsp_dma_busy);
               error_count++;
            end
         end
      end
   end

   task automatic send_command(input action_type act, input logic [15:0] addr,
                               input logic [7:0] wdata, input logic [15:0] dest,
                               input logic [15:0] src, input logic [15:0] cycles);
      start <= 1'b1;
      req_action <= act;
      req_address <= addr;
      req_write_data <= wdata;
      req_dma_dest <= dest;
      req_dma_source <= src;
      req_tick_cycles <= cycles;
      do @(posedge clock); while (busy);
      predict_command(act, addr, wdata, dest, src, cycles);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic bus_read(input logic [15:0] a);
      send_command(ACT_READ, a, 8'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
   endtask

   task automatic bus_write(input logic [15:0] a, input logic [7:0] v);
      send_command(ACT_WRITE, a, v, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic dma_start(input logic [15:0] dest, input logic [15:0] src);
      send_command(ACT_DMA_START, 16'($urandom), 8'($urandom), dest, src,
                   16'($urandom));
   endtask

   task automatic dma_tick(input logic [15:0] cycles);
      send_command(ACT_TICK, 16'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom), cycles);
   endtask

   task automatic write_cartridge(input logic value);
      start <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (8) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cart_present = value;
      @(posedge clock);
   endtask

   // Never reads a ROM byte that has not been written.
   function automatic logic [15:0] safe_read_address(input logic [15:0] a);
      if (cart_present && a < 16'h8000 && !rom_written[a]) begin
         if (rom_addresses.size() > 0)
            return rom_addresses[$urandom_range(rom_addresses.size() - 1)];
         return a | 16'h8000;
      end
      return a;
   endfunction

   task automatic test_unmapped_map;
      bus_read(16'h0000);
      bus_write(16'h7FFF, 8'h5A);
      bus_read(16'hA000);
      bus_write(16'hBFFF, 8'hFF);
      bus_read(16'hFEA0);
      bus_write(16'hFEFF, 8'h11);
      bus_write(16'h8000, 8'hA5);
      bus_read(16'h8000);
      bus_write(16'hC123, 8'h3C);
      bus_read(16'hE123);
      bus_write(16'hFDFF, 8'h77);
      bus_read(16'hDDFF);
      bus_write(16'hFE9F, 8'h81);
      bus_write(16'hFF00, 8'h01);
      bus_write(16'hFF7F, 8'h7F);
      bus_write(16'hFF80, 8'h80);
      bus_write(16'hFFFE, 8'hFE);
      bus_write(16'hFFFF, 8'hFF);
      bus_read(16'hFE9F);
      bus_read(16'hFFFF);
      bus_read(16'hFFFE);
   endtask

   task automatic test_cartridge_rom;
      bus_write(16'h0000, 8'hC3);
      bus_write(16'h7FFF, 8'h3C);
      bus_read(16'h0000);
      bus_read(16'h7FFF);
      bus_read(16'hA000);
   endtask

   task automatic test_dma_cases;
      dma_tick(16'd100);
      dma_start(16'hFE00, 16'hC000);
      dma_tick(16'd0);
      dma_tick(16'd3);
      dma_tick(16'd9);
      bus_read(16'hFE00);
      dma_start(16'hFE00, 16'hFFF0);
      dma_tick(16'd64);
      dma_tick(16'hFFFF);
      bus_read(16'hFE0F);
      bus_read(16'hFE10);
      dma_start(16'hA000, 16'h8000);
      dma_tick(16'd636);
      dma_tick(16'd4);
   endtask

   task automatic test_random(input int count);
      int burst;
      logic [15:0] a;
      burst = $urandom_range(12, 1);
      for (int i = 0; i < count; i++) begin
         a = 16'($urandom);
         case ($urandom_range(9))
            0, 1, 2: bus_read(safe_read_address(a));
            3, 4, 5: bus_write(a, 8'($urandom));
            6: dma_start(16'($urandom), 16'(16'h8000 + $urandom_range(16'h7F5F)));
            default: dma_tick(($urandom_range(15) == 0) ? 16'hFFFF :
                              16'($urandom_range(($urandom_range(3) == 0) ? 700 : 40)));
         endcase
         if (--burst == 0) begin
            idle_gap($urandom_range(15, 1));
            burst = $urandom_range(12, 1);
         end
      end
      dma_tick(16'hFFFF);
   endtask

   initial begin
      for (int i = 0; i < 65536; i++) map_bytes[i] = 8'h00;
      cart_present = 1'b0;
      dma_dest_ptr = '0;
      dma_src_ptr = '0;
      dma_left = '0;
      dma_pending = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_unmapped_map();
      test_dma_cases();
      write_cartridge(1'b1);
      test_cartridge_rom();
      test_random(205);
      write_cartridge(1'b0);
      test_random(205);
      write_cartridge(1'b1);
      test_random(205);
      start <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
